>>> hw/rtl/imat_pkg.sv
// package for the integer matrix arithmetic core
// holds operation, mode and register index codes and the pipeline tag type
// no dependencies
`timescale 1ns / 1ps

package imat_pkg;

	// default sizes
	localparam int MAX_DIM_DEF   = 8;
	localparam int ELEM_BITS_DEF = 32;

	// fixed field widths of the ports
	localparam int POS_W   = 3;
	localparam int VALUE_W = 32;
	localparam int CFG_IDX_W = 3;

	// operation codes of an input transaction
	localparam logic [1:0] OP_LOAD_A = 2'd0;
	localparam logic [1:0] OP_LOAD_B = 2'd1;
	localparam logic [1:0] OP_START  = 2'd2;

	// compute modes
	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_SUB   = 2'd1;
	localparam logic [1:0] MODE_SCALE = 2'd2;
	localparam logic [1:0] MODE_MATMUL = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALAR = 3'd4;

	// tag that travels with each read through the pipeline
	typedef struct packed {
		logic             first;    // first term of a dot product
		logic             term_end; // last term, result goes out
		logic             elem_end; // last element of the result matrix
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} tag_t;

endpackage

>>> hw/rtl/integer_matrix_arithmetic_core.sv
// integer matrix arithmetic core: element stores, sequencer, shared multiply/add unit
// depends on imat_pkg (codes, tag_t)
// single module, stores are inferred memories with registered read
`timescale 1ns / 1ps

// usage
//   configuration: cfg_valid/cfg_ready channel, cfg_index selects mode, rows_a,
//   cols_a, cols_b or scalar_factor; cfg_ready is always high. write only while idle
//   input: a transaction is taken at a clock edge with start high and busy low.
//   op load A / load B writes element_value at (row_index, col_index)
//   and gives no result; busy stays low, so loads may come every cycle.
//   op start launches the compute; busy rises and stays high until the last result
//   results: strobe marks each element for one cycle, row-major, last on the final one.
//   the receiver cannot stall; results are never held back
//   timing: the sequencer issues one store read per cycle; one shared unit does the
//   add, subtract or multiply, then an accumulator sums dot-product terms.
//   an element takes a single read in add, subtract and scalar modes and cols_a reads
//   in product mode; each result passes from its last read through the registered
//   store read, the term register and the output register before it goes out;
//   busy falls as the last result goes out, so the next transaction can be taken
//   right then
//   reset: registers return to mode add, all dimensions 1, scalar 1; store contents
//   stay undefined until written and there is no clearing pass
//   dimension registers of 0 act as 1, above MAX_DIM act as MAX_DIM

module integer_matrix_arithmetic_core #(
	parameter int MAX_DIM   = imat_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = imat_pkg::ELEM_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [imat_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                          cfg_data,
	// command channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           op,
	input  logic [imat_pkg::POS_W-1:0]           row_index,
	input  logic [imat_pkg::POS_W-1:0]           col_index,
	input  logic signed [imat_pkg::VALUE_W-1:0]  element_value,
	// result channel
	output logic                                 strobe,
	output logic [imat_pkg::POS_W-1:0]           out_row,
	output logic [imat_pkg::POS_W-1:0]           out_col,
	output logic signed [imat_pkg::VALUE_W-1:0]  out_value,
	output logic                                 last
);

	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int CNT_W  = $clog2(MAX_DIM + 1);
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	// configuration registers
	logic [1:0]  mode_q;
	logic [3:0]  rows_a_q;
	logic [3:0]  cols_a_q;
	logic [3:0]  cols_b_q;
	logic [31:0] scalar_q;

	// clamped dimensions
	logic [CNT_W-1:0] n_rows;
	logic [CNT_W-1:0] n_inner;
	logic [CNT_W-1:0] n_cols;
	logic             is_matmul;

	// sequencer
	logic [1:0]       state_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic             i_end;
	logic             j_end;
	logic             k_end;
	logic             issue;
	imat_pkg::tag_t   tag_issue;

	// stores
	logic [ELEM_BITS-1:0] mem_a [0:DEPTH-1];
	logic [ELEM_BITS-1:0] mem_b [0:DEPTH-1];
	logic                 take;
	logic                 pos_ok;
	logic                 wr_a;
	logic                 wr_b;
	logic [ADDR_W-1:0]    wr_addr;
	logic [ADDR_W-1:0]    rd_addr_a;
	logic [ADDR_W-1:0]    rd_addr_b;

	// pipeline
	logic                 valid_s1;
	imat_pkg::tag_t       tag_s1;
	logic [ELEM_BITS-1:0] rd_a_s1;
	logic [ELEM_BITS-1:0] rd_b_s1;
	logic                 valid_s2;
	imat_pkg::tag_t       tag_s2;
	logic [ELEM_BITS-1:0] term_s2;
	logic [ELEM_BITS-1:0] term_c;
	logic [ELEM_BITS-1:0] acc_q;
	logic [ELEM_BITS-1:0] sum_c;

	// output registers
	logic                           strobe_q;
	logic                           last_q;
	logic [imat_pkg::POS_W-1:0]     out_row_q;
	logic [imat_pkg::POS_W-1:0]     out_col_q;
	logic signed [ELEM_BITS-1:0]    out_value_q;

	function automatic logic [CNT_W-1:0] clamp_dim(input logic [3:0] d);
		logic [CNT_W-1:0] r;
		if (d == 4'd0) begin
			r = CNT_W'(1);
		end else if (int'(d) > MAX_DIM) begin
			r = CNT_W'(MAX_DIM);
		end else begin
			r = CNT_W'(d);
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// configuration
	// ---------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= imat_pkg::MODE_ADD;
			rows_a_q <= 4'd1;
			cols_a_q <= 4'd1;
			cols_b_q <= 4'd1;
			scalar_q <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				imat_pkg::REG_MODE:   mode_q   <= cfg_data[1:0];
				imat_pkg::REG_ROWS_A: rows_a_q <= cfg_data[3:0];
				imat_pkg::REG_COLS_A: cols_a_q <= cfg_data[3:0];
				imat_pkg::REG_COLS_B: cols_b_q <= cfg_data[3:0];
				imat_pkg::REG_SCALAR: scalar_q <= cfg_data;
				default: ; // writes beyond the register list are dropped
			endcase
		end
	end

	assign is_matmul = (mode_q == imat_pkg::MODE_MATMUL);
	assign n_rows    = clamp_dim(rows_a_q);
	assign n_inner   = clamp_dim(cols_a_q);
	// element-wise modes walk the shape of A
	assign n_cols    = is_matmul ? clamp_dim(cols_b_q) : n_inner;

	// ---------------------------------------------------------------
	// command intake and store writes
	// ---------------------------------------------------------------
	assign busy   = (state_q != ST_IDLE);
	assign take   = start && !busy;
	// positions outside the store are ignored
	assign pos_ok = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
	assign wr_a   = take && (op == imat_pkg::OP_LOAD_A) && pos_ok;
	assign wr_b   = take && (op == imat_pkg::OP_LOAD_B) && pos_ok;
	assign wr_addr = ADDR_W'(row_index[IDX_W-1:0]) * ADDR_W'(MAX_DIM)
		+ ADDR_W'(col_index[IDX_W-1:0]);

	// ---------------------------------------------------------------
	// sequencer: walks i (row), j (column), k (inner term)
	// ---------------------------------------------------------------
	assign issue = (state_q == ST_ISSUE);
	assign k_end = !is_matmul || ((CNT_W'(k_q) + CNT_W'(1)) == n_inner);
	assign j_end = (CNT_W'(j_q) + CNT_W'(1)) == n_cols;
	assign i_end = (CNT_W'(i_q) + CNT_W'(1)) == n_rows;

	// product reads A(i,k) and B(k,j); element-wise modes read A(i,j) and B(i,j)
	assign rd_addr_a = ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(is_matmul ? k_q : j_q);
	assign rd_addr_b = is_matmul ? (ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q))
		: (ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q));

	always_comb begin
		tag_issue.first    = (k_q == '0);
		tag_issue.term_end = k_end;
		tag_issue.elem_end = k_end && j_end && i_end;
		tag_issue.row      = imat_pkg::POS_W'(i_q);
		tag_issue.col      = imat_pkg::POS_W'(j_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take && op == imat_pkg::OP_START) begin
						state_q <= ST_ISSUE;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_ISSUE: begin
					if (!k_end) begin
						k_q <= k_q + IDX_W'(1);
					end else begin
						k_q <= '0;
						if (!j_end) begin
							j_q <= j_q + IDX_W'(1);
						end else begin
							j_q <= '0;
							if (!i_end) begin
								i_q <= i_q + IDX_W'(1);
							end else begin
								// last read issued, let the pipeline empty
								state_q <= ST_DRAIN;
							end
						end
					end
				end
				ST_DRAIN: begin
					if (valid_s2 && tag_s2.elem_end) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// stores, registered read
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[wr_addr] <= element_value[ELEM_BITS-1:0];
		end
		rd_a_s1 <= mem_a[rd_addr_a];
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[wr_addr] <= element_value[ELEM_BITS-1:0];
		end
		rd_b_s1 <= mem_b[rd_addr_b];
	end

	// ---------------------------------------------------------------
	// shared arithmetic unit, then accumulator; all wraps to ELEM_BITS
	// ---------------------------------------------------------------
	always_comb begin
		unique case (mode_q)
			imat_pkg::MODE_ADD:    term_c = rd_a_s1 + rd_b_s1;
			imat_pkg::MODE_SUB:    term_c = rd_a_s1 - rd_b_s1;
			imat_pkg::MODE_SCALE:  term_c = rd_a_s1 * scalar_q[ELEM_BITS-1:0];
			imat_pkg::MODE_MATMUL: term_c = rd_a_s1 * rd_b_s1;
			default:               term_c = rd_a_s1;
		endcase
	end

	assign sum_c = tag_s2.first ? term_s2 : (acc_q + term_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			strobe_q <= valid_s2 && tag_s2.term_end;
			last_q   <= valid_s2 && tag_s2.term_end && tag_s2.elem_end;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		tag_s1  <= tag_issue;
		tag_s2  <= tag_s1;
		term_s2 <= term_c;
		if (valid_s2) begin
			acc_q <= sum_c;
		end
		if (valid_s2 && tag_s2.term_end) begin
			out_row_q   <= tag_s2.row;
			out_col_q   <= tag_s2.col;
			out_value_q <= sum_c;
		end
	end

	assign strobe    = strobe_q;
	assign last      = last_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	// sign-extend the wrapped element to the port width
	assign out_value = imat_pkg::VALUE_W'(out_value_q);

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe)
		else $error("last flagged without a result");

	a_busy_until_final: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("sequencer went idle before the final result");

	a_start_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && op == imat_pkg::OP_START |=> busy)
		else $error("start transaction did not launch the compute");

	a_elementwise_single_term: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !is_matmul |-> tag_s1.first && tag_s1.term_end)
		else $error("element-wise mode issued a multi-term element");

	a_no_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !strobe |=> !strobe)
		else $error("result appeared with no compute running");

endmodule
